/* rtl/core/inversion_disorder_ratio_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the inversion disorder ratio block
// Shared shorthand for the concurrent checks that sit on the block's ports.
// ---------------------------------------------------------------------------
`ifndef INVERSION_DISORDER_RATIO_ASSERT_SVH
`define INVERSION_DISORDER_RATIO_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IDR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IDR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/idr_pkg.sv */
// ---------------------------------------------------------------------------
// Inversion disorder ratio package
// Field widths, defaults and the sequencer state type.
// ---------------------------------------------------------------------------
package idr_pkg;

    localparam int VALUE_W          = 32;
    localparam int INV_W            = 11;
    localparam int LEN_W            = 7;
    localparam int RATIO_W          = 17;
    localparam int DEF_MAX_ELEMENTS = 64;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PAIRS,
        ST_DIV
    } t_idr_state;

endpackage

/* rtl/core/inversion_disorder_ratio.sv */
// ---------------------------------------------------------------------------
// Inversion disorder ratio
// Counts inversion pairs over a sequence and reports the disorder ratio.
// ---------------------------------------------------------------------------
// Input channel (i_valid, o_stall): one signed value per request, i_last on
// the final one. Output channel (o_valid, i_stall): one result per sequence,
// giving the inversion count, the length, the ratio in unsigned Q1.16 and an
// overflow flag when values beyond MAX_ELEMENTS were dropped.
// Each stored value is read back once from the single-port value memory and
// compared against the new one, so o_stall stays high while the values held
// for a request are read back and the new one is written.
// A value that arrives over a full store is dropped and causes no stall unless
// it ends the sequence.
// The final request then passes through a pair-count state and restoring
// division, one quotient bit per cycle, until all 17 bits of the ratio are
// done. A sequence of one value has no pairs and skips the division.
// The result sits in an output register; the next sequence is accepted while
// it waits. If the receiver stalls while a new result is ready, the divider
// holds on its last step until the register frees up.
// Reset clears the counts, the flags and the output valid; the memory is not
// cleared, as only entries already written are ever read.
// ---------------------------------------------------------------------------
module inversion_disorder_ratio #(
    parameter int MAX_ELEMENTS = idr_pkg::DEF_MAX_ELEMENTS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [idr_pkg::VALUE_W-1:0] i_value,
    input  logic                               i_last,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic        [idr_pkg::INV_W-1:0]   o_inversions,
    output logic        [idr_pkg::LEN_W-1:0]   o_length,
    output logic        [idr_pkg::RATIO_W-1:0] o_ratio,
    output logic                               o_overflow
);
    import idr_pkg::*;

    localparam int CW        = $clog2(MAX_ELEMENTS + 1);
    localparam int AW        = $clog2(MAX_ELEMENTS);
    localparam int MAX_PAIRS = MAX_ELEMENTS * (MAX_ELEMENTS - 1) / 2;
    localparam int IW        = $clog2(MAX_PAIRS + 1);
    localparam int PRW       = 2 * CW;
    localparam int SW        = $clog2(RATIO_W);
    localparam logic [SW-1:0] STEP_LAST = SW'(RATIO_W - 1);
    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_ELEMENTS);

    logic signed [VALUE_W-1:0] mem [MAX_ELEMENTS];

    t_idr_state r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [IW-1:0]      r_inv, n_inv;
    logic               r_ovf, n_ovf;
    logic               r_o_valid, n_o_valid;
    logic               r_rd_vld, n_rd_vld;
    logic signed [VALUE_W-1:0] r_val, n_val;
    logic               r_last, n_last;
    logic [CW-1:0]      r_addr, n_addr;
    logic signed [VALUE_W-1:0] r_rd_data;
    logic [IW-1:0]      r_pairs, n_pairs;
    logic [IW-1:0]      r_rem, n_rem;
    logic [RATIO_W-1:0] r_quo, n_quo;
    logic [SW-1:0]      r_step, n_step;
    logic [INV_W-1:0]   r_o_inv, n_o_inv;
    logic [LEN_W-1:0]   r_o_len, n_o_len;
    logic [RATIO_W-1:0] r_o_ratio, n_o_ratio;
    logic               r_o_ovf, n_o_ovf;

    logic               rd_en;
    logic               wr_en;
    logic [CW-1:0]      count_m1;
    logic [PRW-1:0]     pair_prod;
    logic [IW:0]        trial;
    logic [IW:0]        diff;
    logic               ge;
    logic               out_free;
    logic [IW+INV_W-1:0] inv_ext;
    logic [CW+LEN_W-1:0] len_ext;

    assign count_m1  = r_count - 1'b1;
    assign pair_prod = PRW'(r_count) * PRW'(count_m1);
    assign trial     = (r_step == '0) ? {1'b0, r_rem} : {r_rem, 1'b0};
    assign diff      = trial - {1'b0, r_pairs};
    assign ge        = (trial >= {1'b0, r_pairs});
    assign out_free  = !r_o_valid || !i_stall;
    assign inv_ext   = {{INV_W{1'b0}}, r_inv};
    assign len_ext   = {{LEN_W{1'b0}}, r_count};

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_inv     = r_inv;
        n_ovf     = r_ovf;
        n_o_valid = r_o_valid;
        n_rd_vld  = 1'b0;
        n_val     = r_val;
        n_last    = r_last;
        n_addr    = r_addr;
        n_pairs   = r_pairs;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_step    = r_step;
        n_o_inv   = r_o_inv;
        n_o_len   = r_o_len;
        n_o_ratio = r_o_ratio;
        n_o_ovf   = r_o_ovf;
        rd_en     = 1'b0;
        wr_en     = 1'b0;

        if (r_o_valid && !i_stall) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_val  = i_value;
                    n_last = i_last;
                    n_addr = '0;
                    if (r_count < COUNT_MAX) begin
                        n_state = ST_SCAN;
                    end else begin
                        // Store full: the value is dropped but still may end the sequence.
                        n_ovf = 1'b1;
                        if (i_last) begin
                            n_state = ST_PAIRS;
                        end
                    end
                end
            end
            ST_SCAN: begin
                rd_en = (r_addr < r_count);
                if (rd_en) begin
                    n_addr   = r_addr + 1'b1;
                    n_rd_vld = 1'b1;
                end
                if (r_rd_vld && (r_rd_data > r_val)) begin
                    n_inv = r_inv + 1'b1;
                end
                // Once the read pipeline has drained, the new value goes in behind the rest.
                if (!rd_en && !r_rd_vld) begin
                    wr_en   = 1'b1;
                    n_count = r_count + 1'b1;
                    n_state = r_last ? ST_PAIRS : ST_IDLE;
                end
            end
            ST_PAIRS: begin
                n_pairs = (r_count < CW'(2)) ? '0 : pair_prod[IW:1];
                n_rem   = r_inv;
                n_quo   = '0;
                n_step  = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if ((r_pairs == '0) || (r_step == STEP_LAST)) begin
                    if (out_free) begin
                        n_o_valid = 1'b1;
                        n_o_inv   = inv_ext[INV_W-1:0];
                        n_o_len   = len_ext[LEN_W-1:0];
                        n_o_ratio = (r_pairs == '0) ? '0 : {r_quo[RATIO_W-2:0], ge};
                        n_o_ovf   = r_ovf;
                        n_count   = '0;
                        n_inv     = '0;
                        n_ovf     = 1'b0;
                        n_state   = ST_IDLE;
                    end
                end else begin
                    n_quo  = {r_quo[RATIO_W-2:0], ge};
                    n_rem  = ge ? diff[IW-1:0] : trial[IW-1:0];
                    n_step = r_step + 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_inv     <= '0;
            r_ovf     <= 1'b0;
            r_o_valid <= 1'b0;
            r_rd_vld  <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_inv     <= n_inv;
            r_ovf     <= n_ovf;
            r_o_valid <= n_o_valid;
            r_rd_vld  <= n_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val     <= n_val;
        r_last    <= n_last;
        r_addr    <= n_addr;
        r_pairs   <= n_pairs;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_step    <= n_step;
        r_o_inv   <= n_o_inv;
        r_o_len   <= n_o_len;
        r_o_ratio <= n_o_ratio;
        r_o_ovf   <= n_o_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_count[AW-1:0]] <= r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[r_addr[AW-1:0]];
        end
    end

    assign o_stall      = (r_state != ST_IDLE);
    assign o_valid      = r_o_valid;
    assign o_inversions = r_o_inv;
    assign o_length     = r_o_len;
    assign o_ratio      = r_o_ratio;
    assign o_overflow   = r_o_ovf;

endmodule

/* rtl/core/idr_checker.sv */
// ---------------------------------------------------------------------------
// Inversion disorder ratio port checker
// Watches the result channel for values the block can never legally give.
// ---------------------------------------------------------------------------
`include "inversion_disorder_ratio_assert.svh"

module idr_checker #(
    parameter int MAX_ELEMENTS = idr_pkg::DEF_MAX_ELEMENTS
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_valid,
    input logic                               i_stall,
    input logic        [idr_pkg::INV_W-1:0]   o_inversions,
    input logic        [idr_pkg::LEN_W-1:0]   o_length,
    input logic        [idr_pkg::RATIO_W-1:0] o_ratio,
    input logic                               o_overflow
);
    import idr_pkg::*;

    // The length field only wraps when the store is deeper than it can show.
    localparam logic          NO_WRAP  = (MAX_ELEMENTS < (1 << LEN_W));
    localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(MAX_ELEMENTS);
    localparam logic [RATIO_W-1:0] Q16_ONE = RATIO_W'(1 << (RATIO_W - 1));

    `IDR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_inversions) && $stable(o_length) && $stable(o_ratio) && $stable(o_overflow), "result changed while stalled")
    `IDR_ASSERT_SAME(a_ratio_range, i_clk, i_rst_n, o_valid, o_ratio <= Q16_ONE, "ratio above one")
    `IDR_ASSERT_SAME(a_short_seq, i_clk, i_rst_n, o_valid && NO_WRAP && (o_length < LEN_W'(2)), (o_ratio == '0) && (o_inversions == '0), "short sequence gave non-zero result")
    `IDR_ASSERT_SAME(a_ovf_full, i_clk, i_rst_n, o_valid && NO_WRAP && o_overflow, o_length == FULL_LEN, "overflow flagged below full store")

endmodule

bind inversion_disorder_ratio idr_checker #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_idr_checker (.*);

/* bench/tb.sv */
// ---------------------------------------------------------------------------
// Inversion disorder ratio testbench
// Feeds signed value sequences into the block, predicts the inversion count,
// length, Q1.16 disorder ratio and overflow flag of each sequence, and checks
// every result in order under several patterns of idle and stall cycles.
// ---------------------------------------------------------------------------
module tb;
    import idr_pkg::*;

    localparam int DEPTH         = DEF_MAX_ELEMENTS;
    localparam int SETTLE_CYCLES = 2 * DEF_MAX_ELEMENTS + 40;
    localparam int TARGET_VALUES = 650;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } t_value_req;

    typedef struct {
        logic [INV_W-1:0]   inversions;
        logic [LEN_W-1:0]   length;
        logic [RATIO_W-1:0] ratio;
        logic               overflow;
    } t_disorder_result;

    typedef enum {
        SEQ_RANDOM,
        SEQ_CLUSTERED,
        SEQ_RISING,
        SEQ_FALLING,
        SEQ_EXTREMES
    } t_seq_shape;

    logic                      i_clk    = 1'b0;
    logic                      i_rst_n  = 1'b0;
    logic                      i_valid  = 1'b0;
    logic signed [VALUE_W-1:0] i_value  = '0;
    logic                      i_last   = 1'b0;
    logic                      i_stall  = 1'b0;
    logic                      o_stall;
    logic                      o_valid;
    logic [INV_W-1:0]          o_inversions;
    logic [LEN_W-1:0]          o_length;
    logic [RATIO_W-1:0]        o_ratio;
    logic                      o_overflow;

    t_value_req       value_queue[$];
    t_disorder_result pending_results[$];

    // Predictor state for the sequence in progress.
    logic signed [VALUE_W-1:0] held_values[DEPTH];
    int                        held_count;
    int                        inversion_sum;
    logic                      dropped_any;

    int values_queued;
    int values_driven;
    int values_taken;
    int sequences_checked;
    int overflow_results;
    int error_count;
    int idle_pct;
    int stall_pct;

    inversion_disorder_ratio i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_value      (i_value),
        .i_last       (i_last),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_inversions (o_inversions),
        .o_length     (o_length),
        .o_ratio      (o_ratio),
        .o_overflow   (o_overflow)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic absorb_value(input logic signed [VALUE_W-1:0] v, input logic last_flag);
        t_disorder_result res;
        longint           pairs;
        if (held_count < DEPTH) begin
            for (int k = 0; k < held_count; k++) begin
                if (held_values[k] > v)
                    inversion_sum++;
            end
            held_values[held_count] = v;
            held_count++;
        end else begin
            dropped_any = 1'b1;
        end
        if (last_flag) begin
            res.inversions = inversion_sum[INV_W-1:0];
            res.length     = held_count[LEN_W-1:0];
            if (held_count < 2) begin
                res.ratio = '0;
            end else begin
                pairs     = longint'(held_count) * longint'(held_count - 1) / 2;
                res.ratio = RATIO_W'((longint'(inversion_sum) * 65536) / pairs);
            end
            res.overflow = dropped_any;
            pending_results.push_back(res);
            held_count    = 0;
            inversion_sum = 0;
            dropped_any   = 1'b0;
        end
    endtask

    task automatic check_result();
        t_disorder_result want;
        if (pending_results.size() == 0) begin
            $error("result with no sequence outstanding: inversions %0d length %0d",
                   o_inversions, o_length);
            error_count++;
        end else begin
            want = pending_results.pop_front();
            sequences_checked++;
            if (o_overflow)
                overflow_results++;
            if (o_inversions !== want.inversions) begin
                $error("inversions: expected %0d, got %0d", want.inversions, o_inversions);
                error_count++;
            end
            if (o_length !== want.length) begin
                $error("length: expected %0d, got %0d", want.length, o_length);
                error_count++;
            end
            if (o_ratio !== want.ratio) begin
                $error("ratio: expected %0d, got %0d", want.ratio, o_ratio);
                error_count++;
            end
            if (o_overflow !== want.overflow) begin
                $error("overflow: expected %0d, got %0d", want.overflow, o_overflow);
                error_count++;
            end
        end
    endtask

    // Monitor: both handshakes are sampled on the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                absorb_value(i_value, i_last);
                values_taken++;
            end
            if (o_valid && !i_stall)
                check_result();
        end
    end

    // Driver: a request is held until taken, then the next one may follow a gap.
    always @(negedge i_clk) begin
        t_value_req req;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
            if (values_driven == values_taken) begin
                if (value_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    req = value_queue.pop_front();
                    i_value <= req.value;
                    i_last  <= req.last;
                    i_valid <= 1'b1;
                    values_driven++;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    task automatic queue_value(input logic signed [VALUE_W-1:0] v, input logic last_flag);
        t_value_req req;
        req.value = v;
        req.last  = last_flag;
        value_queue.push_back(req);
        values_queued++;
    endtask

    task automatic queue_sequence(input int len, input t_seq_shape shape);
        logic signed [VALUE_W-1:0] base;
        logic signed [VALUE_W-1:0] v;
        int                        step;
        base = $urandom_range(32'h4000_0000, 0);
        step = $urandom_range(1000, 1);
        for (int i = 0; i < len; i++) begin
            case (shape)
                SEQ_CLUSTERED: v = $signed($urandom_range(6)) - 3;
                SEQ_RISING:    v = base + i * step;
                SEQ_FALLING:   v = base - i * step;
                SEQ_EXTREMES: begin
                    case ($urandom_range(4))
                        0:       v = 32'sh8000_0000;
                        1:       v = 32'sh7fff_ffff;
                        2:       v = -1;
                        3:       v = 0;
                        default: v = 1;
                    endcase
                end
                default:       v = $urandom;
            endcase
            queue_value(v, i == len - 1);
        end
    endtask

    task automatic drain();
        while (values_taken != values_queued || pending_results.size() != 0)
            @(negedge i_clk);
    endtask

    initial begin
        int phase_start;
        int len;
        held_count    = 0;
        inversion_sum = 0;
        dropped_any   = 1'b0;
        idle_pct      = 0;
        stall_pct     = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed sequences: single value, signed extremes, ties and full disorder.
        queue_value(5, 1'b1);
        queue_value(32'sh7fff_ffff, 1'b0);
        queue_value(32'sh8000_0000, 1'b1);
        queue_value(32'sh8000_0000, 1'b0);
        queue_value(32'sh7fff_ffff, 1'b1);
        queue_value(0, 1'b0);
        queue_value(-1, 1'b1);
        queue_value(1, 1'b0);
        queue_value(-1, 1'b0);
        queue_value(0, 1'b1);
        queue_value(7, 1'b0);
        queue_value(7, 1'b0);
        queue_value(7, 1'b1);
        queue_value(3, 1'b0);
        queue_value(2, 1'b0);
        queue_value(1, 1'b0);
        queue_value(0, 1'b1);
        queue_value(1, 1'b0);
        queue_value(3, 1'b0);
        queue_value(2, 1'b1);
        queue_value(-5, 1'b0);
        queue_value(32'sh7fff_ffff, 1'b0);
        queue_value(32'sh8000_0000, 1'b0);
        queue_value(-5, 1'b1);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 47; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 47; end
                default: begin idle_pct = 23; stall_pct = 23; end
            endcase
            phase_start = values_queued;
            // A fully reversed store, and a sequence that runs past the store.
            if (phase == 1)
                queue_sequence(DEPTH, SEQ_FALLING);
            if (phase == 2)
                queue_sequence(DEPTH + 6, SEQ_RANDOM);
            while (values_queued - phase_start < TARGET_VALUES / 4) begin
                if ($urandom_range(99) < 4)
                    len = $urandom_range(DEPTH + 6, DEPTH - 4);
                else
                    len = $urandom_range(12, 1);
                queue_sequence(len, t_seq_shape'($urandom_range(4)));
            end
            // The sender holds off here until every result of the phase is in.
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Ran %0d values in %0d sequences; %0d results reported dropped values.",
                 values_taken, sequences_checked, overflow_results);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

/* inversion_disorder_ratio.f */
+incdir+rtl/core
rtl/core/idr_pkg.sv
rtl/core/inversion_disorder_ratio.sv
rtl/core/idr_checker.sv
bench/tb.sv
